### rtl/rti_pkg.sv
// types and constants for the ray/triangle intersection unit
// no dependencies
`default_nettype none
package rti_pkg;
	localparam int CoordW = 16;
	localparam int EdgeW  = 17;
	localparam int CrsW   = 36;
	localparam int DotW   = 56;
	localparam int DistW  = 32;
	localparam int EpsW   = 32;
	localparam int QuoW   = 48;
	localparam int NumRegs = 7;
	localparam int IdxW   = 3;

	localparam logic [IdxW-1:0] RegOrgX = 3'd0;
	localparam logic [IdxW-1:0] RegOrgY = 3'd1;
	localparam logic [IdxW-1:0] RegOrgZ = 3'd2;
	localparam logic [IdxW-1:0] RegDirX = 3'd3;
	localparam logic [IdxW-1:0] RegDirY = 3'd4;
	localparam logic [IdxW-1:0] RegDirZ = 3'd5;
	localparam logic [IdxW-1:0] RegEps  = 3'd6;

	typedef struct packed {
		logic signed [CoordW-1:0] a_x, a_y, a_z;
		logic signed [CoordW-1:0] b_x, b_y, b_z;
		logic signed [CoordW-1:0] c_x, c_y, c_z;
	} tri_t;

	typedef struct packed {
		logic                     hit;
		logic signed [DistW-1:0]  distance;
	} res_t;
endpackage
`default_nettype wire

### rtl/rti_if.sv
// valid/ready channel interface carrying one payload
// depends on nothing; payload type is a parameter
`default_nettype none
interface rti_if #(parameter type payload_t = logic) (input wire logic clk);
	logic     valid;
	logic     ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### rtl/rti_divider.sv
// pipelined restoring divider: one quotient bit per stage
// depends on rti_pkg
`default_nettype none
module rti_divider
	import rti_pkg::*;
#(
	parameter int NumW = 56,
	parameter int DenW = 56,
	parameter int QW = 48,
	parameter int TagW = 34
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            en,
	input  wire logic            in_valid,
	input  wire logic [NumW-1:0] num,
	input  wire logic [DenW-1:0] den,
	input  wire logic [TagW-1:0] in_tag,
	output logic                 out_valid,
	output logic [QW-1:0]        quo,
	output logic [TagW-1:0]      out_tag
);
	localparam int RW = DenW + 1;
	// numerator scaled by 2^16; quotient bits above QW are known zero only
	// after saturation, so the top bits are folded into a sticky overflow
	localparam int SW = NumW + 16;

	logic [QW:0]       v_q;
	logic [RW-1:0]     r_q   [QW+1];
	logic [SW-1:0]     n_q   [QW+1];
	logic [DenW-1:0]   d_q   [QW+1];
	logic [QW-1:0]     qb_q  [QW+1];
	logic [TagW-1:0]   t_q   [QW+1];
	logic              ov_q  [QW+1];

	// stage 0 loads; remainder starts with bits above QW (overflow check)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q[0] <= 1'b0;
		end else if (en) begin
			v_q[0] <= in_valid;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			n_q[0]  <= {num, 16'd0};
			d_q[0]  <= den;
			r_q[0]  <= RW'({num, 16'd0} >> QW);
			qb_q[0] <= '0;
			t_q[0]  <= in_tag;
			// quotient >= 2^QW iff (num<<16) >> QW >= den
			ov_q[0] <= ({{(DenW){1'b0}}, num, 16'd0} >> QW) >= {{(SW){1'b0}}, den};
		end
	end

	genvar g;
	generate
		for (g = 0; g < QW; g++) begin : g_stage
			logic [RW-1:0] sh;
			logic [RW:0]   diff;
			assign sh   = {r_q[g][RW-2:0], n_q[g][QW-1-g]};
			assign diff = {1'b0, sh} - {2'b00, d_q[g]};
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					v_q[g+1] <= 1'b0;
				end else if (en) begin
					v_q[g+1] <= v_q[g];
				end
			end
			always_ff @(posedge clk) begin
				if (en) begin
					n_q[g+1]  <= n_q[g];
					d_q[g+1]  <= d_q[g];
					t_q[g+1]  <= t_q[g];
					ov_q[g+1] <= ov_q[g];
					r_q[g+1]  <= diff[RW] ? sh : diff[RW-1:0];
					qb_q[g+1] <= {qb_q[g][QW-2:0], ~diff[RW]};
				end
			end
		end
	endgenerate

	assign out_valid = v_q[QW];
	assign quo       = ov_q[QW] ? {QW{1'b1}} : qb_q[QW];
	assign out_tag   = t_q[QW];
endmodule
`default_nettype wire

### rtl/rti_geometry.sv
// geometry front end: edges, cross products, dot products and hit tests
// depends on rti_pkg
`default_nettype none
module rti_geometry
	import rti_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     en,
	input  wire logic                     in_valid,
	input  wire tri_t                     tri_in,
	input  wire logic signed [CoordW-1:0] org [3],
	input  wire logic signed [CoordW-1:0] dir [3],
	input  wire logic [EpsW-1:0]          eps,
	output logic                          out_valid,
	output logic                          out_hit,
	output logic                          out_neg,
	output logic [DotW-1:0]               out_tmag,
	output logic [DotW-1:0]               out_dmag
);
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic signed [EdgeW-1:0] e1_s1 [3], e2_s1 [3], s_s1 [3];
	logic signed [CrsW-1:0]  n_s2 [3], q_s2 [3];
	logic signed [EdgeW-1:0] e1_s2 [3], e2_s2 [3], s_s2 [3];
	logic signed [DotW-1:0]  det_s3, uu_s3, vv_s3, tt_s3;
	logic                    par_s4;
	logic signed [DotW-1:0]  dm_s4, uu_s4, vv_s4, tt_s4;
	logic                    hit_s5, neg_s5;
	logic [DotW-1:0]         tm_s5, dm_s5;
	logic signed [CoordW-1:0] va [3], vb [3], vc [3];

	assign va = '{tri_in.a_x, tri_in.a_y, tri_in.a_z};
	assign vb = '{tri_in.b_x, tri_in.b_y, tri_in.b_z};
	assign vc = '{tri_in.c_x, tri_in.c_y, tri_in.c_z};

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5} <= '0;
		end else if (en) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5} <= {in_valid, v_s1, v_s2, v_s3, v_s4};
		end
	end

	// stage 1: edge vectors
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				e1_s1[i] <= EdgeW'(vb[i]) - EdgeW'(va[i]);
				e2_s1[i] <= EdgeW'(vc[i]) - EdgeW'(va[i]);
				s_s1[i]  <= EdgeW'(org[i]) - EdgeW'(va[i]);
			end
		end
	end

	// stage 2: n = dir x e2, q = s x e1
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				n_s2[i] <= CrsW'(dir[(i+1)%3] * e2_s1[(i+2)%3])
					- CrsW'(e2_s1[(i+1)%3] * dir[(i+2)%3]);
				q_s2[i] <= CrsW'(s_s1[(i+1)%3] * e1_s1[(i+2)%3])
					- CrsW'(e1_s1[(i+1)%3] * s_s1[(i+2)%3]);
			end
			e1_s2 <= e1_s1;
			e2_s2 <= e2_s1;
			s_s2  <= s_s1;
		end
	end

	// stage 3: determinant and barycentric numerators
	always_ff @(posedge clk) begin
		if (en) begin
			det_s3 <= DotW'(e1_s2[0] * n_s2[0]) + DotW'(e1_s2[1] * n_s2[1])
				+ DotW'(e1_s2[2] * n_s2[2]);
			uu_s3 <= DotW'(s_s2[0] * n_s2[0]) + DotW'(s_s2[1] * n_s2[1])
				+ DotW'(s_s2[2] * n_s2[2]);
			vv_s3 <= DotW'(dir[0] * q_s2[0]) + DotW'(dir[1] * q_s2[1])
				+ DotW'(dir[2] * q_s2[2]);
			tt_s3 <= DotW'(e2_s2[0] * q_s2[0]) + DotW'(e2_s2[1] * q_s2[1])
				+ DotW'(e2_s2[2] * q_s2[2]);
		end
	end

	// stage 4: sign normalize and parallel test
	always_ff @(posedge clk) begin
		if (en) begin
			if (det_s3 < 0) begin
				dm_s4 <= -det_s3;
				uu_s4 <= -uu_s3;
				vv_s4 <= -vv_s3;
				tt_s4 <= -tt_s3;
			end else begin
				dm_s4 <= det_s3;
				uu_s4 <= uu_s3;
				vv_s4 <= vv_s3;
				tt_s4 <= tt_s3;
			end
			par_s4 <= ((det_s3 < 0) ? -det_s3 : det_s3) <= $signed({24'd0, eps});
		end
	end

	// stage 5: barycentric range tests, distance magnitude
	always_ff @(posedge clk) begin
		if (en) begin
			hit_s5 <= !par_s4 && !uu_s4[DotW-1] && (uu_s4 <= dm_s4) && !vv_s4[DotW-1]
				&& ((uu_s4 + vv_s4) <= dm_s4);
			neg_s5 <= tt_s4[DotW-1];
			tm_s5  <= tt_s4[DotW-1] ? DotW'(-tt_s4) : DotW'(tt_s4);
			dm_s5  <= (dm_s4 == 0) ? DotW'(1) : DotW'(dm_s4);
		end
	end

	assign out_valid = v_s5;
	assign out_hit   = hit_s5;
	assign out_neg   = neg_s5;
	assign out_tmag  = tm_s5;
	assign out_dmag  = dm_s5;
endmodule
`default_nettype wire

### rtl/ray_triangle_intersect_unit.sv
// ray/triangle intersection unit, Moller-Trumbore, one triangle per cycle
// pipeline: 5 geometry stages + 49 divider stages + 1 output register
// throughput: one transaction per cycle; the whole pipe advances when the
// output register is empty or being taken
// reset clears all valid bits and loads ray registers to origin 0, dir (256,0,0)
// depends on rti_pkg, rti_if, rti_geometry, rti_divider
`default_nettype none
module ray_triangle_intersect_unit
	import rti_pkg::*;
(
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            cfg_we,
	input  wire logic [IdxW-1:0] cfg_index,
	input  wire logic [EpsW-1:0] cfg_data,
	rti_if.sink                  tri_in,
	rti_if.source                res_out
);
	logic signed [CoordW-1:0] org_q [3];
	logic signed [CoordW-1:0] dir_q [3];
	logic [EpsW-1:0]          eps_q;
	logic                     en;
	logic                     g_valid, g_hit, g_neg;
	logic [DotW-1:0]          g_tmag, g_dmag;
	logic                     d_valid;
	logic [QuoW-1:0]          d_quo;
	logic [1:0]               d_tag;
	logic                     out_v_q;
	res_t                     out_q;
	logic [DistW-1:0]         mag32;
	logic                     big;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			org_q <= '{default: '0};
			dir_q <= '{16'sd256, 16'sd0, 16'sd0};
			eps_q <= 32'd168;
		end else if (cfg_we) begin
			case (cfg_index)
				RegOrgX: org_q[0] <= cfg_data[CoordW-1:0];
				RegOrgY: org_q[1] <= cfg_data[CoordW-1:0];
				RegOrgZ: org_q[2] <= cfg_data[CoordW-1:0];
				RegDirX: dir_q[0] <= cfg_data[CoordW-1:0];
				RegDirY: dir_q[1] <= cfg_data[CoordW-1:0];
				RegDirZ: dir_q[2] <= cfg_data[CoordW-1:0];
				RegEps:  eps_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// pipeline advances when the output slot is free or being taken
	assign en = !out_v_q || res_out.ready;
	assign tri_in.ready = en;

	rti_geometry u_geom (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(tri_in.valid && en), .tri_in(tri_in.data),
		.org(org_q), .dir(dir_q), .eps(eps_q),
		.out_valid(g_valid), .out_hit(g_hit), .out_neg(g_neg),
		.out_tmag(g_tmag), .out_dmag(g_dmag)
	);

	rti_divider #(.NumW(DotW), .DenW(DotW), .QW(QuoW), .TagW(2)) u_div (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(g_valid), .num(g_tmag), .den(g_dmag), .in_tag({g_hit, g_neg}),
		.out_valid(d_valid), .quo(d_quo), .out_tag(d_tag)
	);

	// saturate magnitude and apply sign
	assign big   = |d_quo[QuoW-1:DistW];
	assign mag32 = big ? 32'hFFFF_FFFF : d_quo[DistW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en) begin
			out_v_q <= d_valid;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			out_q.hit <= d_tag[1];
			if (!d_tag[1]) begin
				out_q.distance <= '0;
			end else if (d_tag[0]) begin
				out_q.distance <= mag32[DistW-1] ? 32'sh8000_0000 : -$signed(mag32);
			end else begin
				out_q.distance <= mag32[DistW-1] ? 32'sh7FFF_FFFF : $signed(mag32);
			end
		end
	end

	assign res_out.valid = out_v_q;
	assign res_out.data  = out_q;
endmodule
`default_nettype wire
